@@ rtl/assert_macros.svh @@
// Assertion macros shared by the queue RTL.
// Each macro expects signals clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define SPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/spq_pkg.sv @@
// Package for the stable priority queue: field widths, codes, FSM state type.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int OP_W   = 2;
  localparam int VAL_W  = 32;
  localparam int PRIN_W = 16;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_POP     = 2'd1;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_PICK,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  // Qualifiers for a word coming back from the entry store.
  typedef struct packed {
    logic vld;
    logic first;
  } scan_ctl_t;

endpackage

@@ rtl/stable_priority_queue.sv @@
// Top level of the stable priority queue: control FSM, entry store, tracker.
// Depends on spq_pkg, spq_mem, spq_scan and assert_macros.svh.
`timescale 1ns / 1ps
//
//  Channel   Ports                                         Handshake
//  -------   --------------------------------------------  -----------------------
//  in        in_operation, in_value_in, in_priority_in     start & !busy
//  out       out_value_out, out_status, out_occupancy      out_strobe, one cycle
//
//  Enqueue, removal from an empty queue and the unused code: busy stays low,
//  result in the cycle after accept, so a word can be taken every cycle.
//  Pop/dequeue of a non-empty queue: busy through SCAN, WAIT, PICK, SHIFT and
//  FINISH, since the entry store has a single read port: one pass reads every
//  entry, a second moves the entries behind the winner up by one place.
//  Reset (rst_n low, synchronous) empties the queue; the store is not cleared.
//  The receiver cannot stall: each result is on the ports for one cycle only.

module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          in_operation,
  input  logic signed [VAL_W-1:0]  in_value_in,
  input  logic [PRIN_W-1:0]        in_priority_in,
  output logic                     out_strobe,
  output logic signed [VAL_W-1:0]  out_value_out,
  output logic [STAT_W-1:0]        out_status,
  output logic [OCC_W-1:0]         out_occupancy
);

`include "assert_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = PRIO_BITS + VAL_W;

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;  // entries held
  logic [OP_W-1:0]   op_r, op_nxt;        // opcode of the word in flight
  logic [CW-1:0]     rp_r, rp_nxt;        // read pointer for both passes

  // read pipeline: qualifiers for the word coming back next cycle
  logic              rd_vld_r;
  logic              rd_shift_r;
  logic [AW-1:0]     rd_tag_r;

  // result registers
  logic                    out_strobe_r, out_strobe_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [STAT_W-1:0]       out_status_r, out_status_nxt;
  logic [OCC_W-1:0]        out_occ_r, out_occ_nxt;

  // store ports
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [EW-1:0]     mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [EW-1:0]     mem_rdata;

  logic              enq_we;
  logic              shift_we;
  logic              accept;
  logic [31:0]       prio_ext;
  logic [PRIO_BITS-1:0] prio_in;
  logic [31:0]       occ_ext;

  scan_ctl_t               scan_ctl;
  logic [AW-1:0]           best_idx;
  logic signed [VAL_W-1:0] best_value;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // only the low PRIO_BITS of the priority are kept
  assign prio_ext = 32'(in_priority_in);
  assign prio_in  = prio_ext[PRIO_BITS-1:0];

  // ---------------------------------------------------------------------
  // Store instance; writes come from an enqueue or from the move-up pass.
  // Reads always run ahead of writes, so no entry is read while its write
  // is pending; busy holds off a new word until the last write lands.
  // ---------------------------------------------------------------------
  assign shift_we  = rd_vld_r && rd_shift_r;
  assign mem_we    = enq_we || shift_we;
  assign mem_waddr = shift_we ? AW'(rd_tag_r - 1'b1) : count_r[AW-1:0];
  assign mem_wdata = shift_we ? mem_rdata : {prio_in, in_value_in};

  spq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // tracker sees words of the first pass only
  assign scan_ctl.vld   = rd_vld_r && !rd_shift_r;
  assign scan_ctl.first = (rd_tag_r == '0);

  spq_scan #(
    .AW        (AW),
    .PRIO_BITS (PRIO_BITS)
  ) u_scan (
    .clk        (clk),
    .ctl        (scan_ctl),
    .idx        (rd_tag_r),
    .prio       (mem_rdata[EW-1:VAL_W]),
    .value      (mem_rdata[VAL_W-1:0]),
    .best_idx   (best_idx),
    .best_value (best_value)
  );

  // ---------------------------------------------------------------------
  // FSM: next state, store reads, results
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    rp_nxt         = rp_r;
    mem_re         = 1'b0;
    mem_raddr      = rp_r[AW-1:0];
    enq_we         = 1'b0;
    out_strobe_nxt = 1'b0;
    out_value_nxt  = '0;
    out_status_nxt = STAT_OK;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt = in_operation;
          if (in_operation == OP_ENQUEUE) begin
            out_strobe_nxt = 1'b1;
            if (count_r == CW'(DEPTH)) begin
              out_status_nxt = STAT_FULL;   // dropped
            end else begin
              enq_we    = 1'b1;
              count_nxt = CW'(count_r + 1'b1);
            end
          end else if (in_operation inside {OP_POP, OP_DEQUEUE}) begin
            if (count_r == '0) begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = STAT_EMPTY;
            end else begin
              rp_nxt    = '0;
              state_nxt = ST_SCAN;
            end
          end else begin
            out_strobe_nxt = 1'b1;          // unused code: no change
          end
        end
      end
      ST_SCAN: begin
        mem_re = 1'b1;
        if (rp_r == CW'(count_r - 1'b1)) begin
          state_nxt = ST_WAIT;
        end else begin
          rp_nxt = CW'(rp_r + 1'b1);
        end
      end
      ST_WAIT: begin
        state_nxt = ST_PICK;                // last word enters tracker
      end
      ST_PICK: begin
        rp_nxt    = CW'(CW'(best_idx) + 1'b1);
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (rp_r < count_r) begin
          mem_re = 1'b1;
          rp_nxt = CW'(rp_r + 1'b1);
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        count_nxt      = CW'(count_r - 1'b1);
        out_strobe_nxt = 1'b1;
        out_value_nxt  = (op_r == OP_POP) ? best_value : '0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    occ_ext     = 32'(count_nxt);
    out_occ_nxt = occ_ext[OCC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      rd_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rd_vld_r     <= mem_re;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    rp_r         <= rp_nxt;
    rd_shift_r   <= (state_r == ST_SHIFT);
    rd_tag_r     <= mem_raddr;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_strobe    = out_strobe_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `SPQ_ASSERT_NEXT(a_pop_starts_scan,
    accept && (in_operation == OP_POP || in_operation == OP_DEQUEUE) && (count_r != '0),
    state_r == ST_SCAN, "pop of non-empty queue did not start the scan")

  `SPQ_ASSERT_NEXT(a_finish_decrements, state_r == ST_FINISH,
    (count_r == CW'($past(count_r) - 1'b1)) && out_strobe_r,
    "finished removal did not drop the count and strobe")

  `SPQ_ASSERT_IMPL(a_shift_in_range, shift_we,
    (rd_tag_r != '0) && (CW'(rd_tag_r) < count_r),
    "move-up write outside the held entries")

  `SPQ_ASSERT_IMPL(a_single_writer, enq_we, !shift_we,
    "enqueue write collides with move-up write")

endmodule

@@ rtl/spq_mem.sv @@
// Entry store: simple dual-port RAM, one write and one registered read port.
// No package dependencies.
`timescale 1ns / 1ps

module spq_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int WIDTH = 48
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/spq_scan.sv @@
// Best-entry tracker: folds a stream of store words into the first maximum.
// Depends on spq_pkg (scan_ctl_t, VAL_W).
`timescale 1ns / 1ps

module spq_scan
  import spq_pkg::*;
#(
  parameter int AW        = 4,
  parameter int PRIO_BITS = 16
) (
  input  logic                    clk,
  input  scan_ctl_t               ctl,
  input  logic [AW-1:0]           idx,
  input  logic [PRIO_BITS-1:0]    prio,
  input  logic signed [VAL_W-1:0] value,
  output logic [AW-1:0]           best_idx,
  output logic signed [VAL_W-1:0] best_value
);

  logic [AW-1:0]           best_idx_r;
  logic [PRIO_BITS-1:0]    best_prio_r;
  logic signed [VAL_W-1:0] best_value_r;

  // strict compare keeps the earliest of equal priorities
  always_ff @(posedge clk) begin
    if (ctl.vld && (ctl.first || (prio > best_prio_r))) begin
      best_idx_r   <= idx;
      best_prio_r  <= prio;
      best_value_r <= value;
    end
  end

  assign best_idx   = best_idx_r;
  assign best_value = best_value_r;

endmodule

@@ tb/sv/tb_stable_priority_queue.sv @@
// Self-checking bench for stable_priority_queue: directed corner words, then random traffic.
// Predicts every result with its own queue model; depends on spq_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_stable_priority_queue;
  import spq_pkg::*;

  localparam int DEPTH     = 16;
  localparam int PRIO_BITS = 16;
  localparam logic [PRIN_W-1:0] PRIO_MASK = PRIN_W'((64'd1 << PRIO_BITS) - 1);

  // Code three is not defined by the package; the block treats it as a no-op.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_WORDS = 1525;
  localparam int TAIL_CYCLES  = 40;    // outlasts the longest removal
  localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [STAT_W-1:0]       status;
    logic [OCC_W-1:0]        occupancy;
  } queue_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [OP_W-1:0]         in_operation;
  logic signed [VAL_W-1:0] in_value_in;
  logic [PRIN_W-1:0]       in_priority_in;
  logic                    out_strobe;
  logic signed [VAL_W-1:0] out_value_out;
  logic [STAT_W-1:0]       out_status;
  logic [OCC_W-1:0]        out_occupancy;

  // Shadow of the queue contents, kept in arrival order.
  logic signed [VAL_W-1:0] shadow_values [DEPTH];
  logic [PRIN_W-1:0]       shadow_prios  [DEPTH];
  int                      shadow_count = 0;

  queue_result_t pending_results[$];
  int            mismatches   = 0;
  int            stall_cycles = 0;
  bit            burst_mode   = 1'b0;  // when set, the sender never pauses

  stable_priority_queue #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_value_in    (in_value_in),
    .in_priority_in (in_priority_in),
    .out_strobe     (out_strobe),
    .out_value_out  (out_value_out),
    .out_status     (out_status),
    .out_occupancy  (out_occupancy)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Applies one word to the shadow queue and returns the result it must produce.
  // Removal picks the first entry of the highest priority, then closes the gap.
  function automatic queue_result_t serve_queue_word(input logic [OP_W-1:0] op,
                                                     input logic signed [VAL_W-1:0] value,
                                                     input logic [PRIN_W-1:0] prio);
    queue_result_t r;
    int            best;
    int            i;
    r.value  = '0;
    r.status = STAT_OK;
    if (op == OP_ENQUEUE) begin
      if (shadow_count >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        shadow_values[shadow_count] = value;
        shadow_prios[shadow_count]  = prio & PRIO_MASK;
        shadow_count++;
      end
    end else if (op == OP_POP || op == OP_DEQUEUE) begin
      if (shadow_count == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        best = 0;
        for (i = 1; i < shadow_count; i++) begin
          if (shadow_prios[i] > shadow_prios[best]) best = i;  // strict: earliest wins ties
        end
        if (op == OP_POP) r.value = shadow_values[best];
        for (i = best; i < shadow_count - 1; i++) begin
          shadow_values[i] = shadow_values[i + 1];
          shadow_prios[i]  = shadow_prios[i + 1];
        end
        shadow_count--;
      end
    end
    // unused code: nothing changes, status ok
    r.occupancy = OCC_W'(shadow_count);
    return r;
  endfunction

  // Sends one word. start is left high after the accept so that a word with no
  // gap follows back to back; anything that waits outside this task lowers it first.
  task automatic send_word(input logic [OP_W-1:0] op,
                           input logic signed [VAL_W-1:0] value,
                           input logic [PRIN_W-1:0] prio);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_value_in    <= value;
    in_priority_in <= prio;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    pending_results.push_back(serve_queue_word(op, value, prio));
  endtask

  // Stops sending and waits until every result has come back, plus the tail.
  task automatic drain_queue;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Removal and the unused code on an empty queue; the enqueue fields are ignored.
  task automatic test_empty_queue;
    send_word(OP_POP, 32'sh7fffffff, 16'hffff);
    send_word(OP_DEQUEUE, -32'sd1, 16'h0000);
    send_word(OP_UNUSED, 32'sh80000000, 16'hffff);
  endtask

  // Fill with extreme values and tied priorities, then overflow by one.
  task automatic test_fill_and_overflow;
    logic signed [VAL_W-1:0] vals  [DEPTH];
    logic [PRIN_W-1:0]       prios [DEPTH];
    int                      i;
    vals  = '{32'sh80000000, 32'sh7fffffff, 32'sd0, -32'sd1,
              32'sd1, 32'sh55555555, 32'shaaaaaaaa, 32'sd100,
              -32'sd100, 32'sh7ffffffe, 32'sh80000001, 32'sd42,
              32'sh0000ffff, 32'shffff0000, 32'sd7, -32'sd7};
    prios = '{16'h0000, 16'hffff, 16'h0000, 16'hffff,
              16'h8000, 16'h7fff, 16'h8000, 16'h0001,
              16'hffff, 16'h5555, 16'haaaa, 16'h0001,
              16'h8000, 16'h0000, 16'hfffe, 16'hffff};
    for (i = 0; i < DEPTH; i++) send_word(OP_ENQUEUE, vals[i], prios[i]);
    send_word(OP_ENQUEUE, 32'sh12345678, 16'hffff);  // full: dropped
    send_word(OP_UNUSED, 32'sd0, 16'h0000);          // no-op with a full queue
  endtask

  // Ties on the top priority must come out in arrival order.
  task automatic test_removals;
    send_word(OP_POP, 32'sd0, 16'h0000);
    send_word(OP_DEQUEUE, 32'sh7fffffff, 16'hffff);  // removes, reports zero
    send_word(OP_POP, 32'sd0, 16'h0000);
    send_word(OP_POP, -32'sd1, 16'hffff);
  endtask

  // Switches at random between fill-heavy and drain-heavy stretches so that both the full and
  // the empty boundary get hit; priorities lean on a few values to force ties.
  task automatic test_random_traffic(input int n_words);
    int                      i;
    int                      pick;
    int                      enq_share;
    bit                      fill_bias;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
    logic [PRIN_W-1:0]       prio;
    fill_bias = 1'b1;
    for (i = 0; i < n_words; i++) begin
      if (i % 64 == 0) begin
        fill_bias  = 1'($urandom_range(0, 1));
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      enq_share = fill_bias ? 70 : 35;
      pick = $urandom_range(0, 99);
      if (pick >= 95)           op = OP_UNUSED;
      else if (pick < enq_share) op = OP_ENQUEUE;
      else if (pick % 2 == 1)   op = OP_POP;
      else                      op = OP_DEQUEUE;

      case ($urandom_range(0, 4))
        0:       value = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        default: value = $urandom;
      endcase

      pick = $urandom_range(0, 9);
      if (pick < 5)      prio = PRIN_W'($urandom_range(0, 3));
      else if (pick < 7) prio = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      else               prio = PRIN_W'($urandom_range(0, 65535));

      send_word(op, value, prio);
    end
    burst_mode = 1'b0;
  endtask

  // Result checker: every strobe is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result: value %0d status %0d occupancy %0d",
                   $time, out_value_out, out_status, out_occupancy);
      end else begin
        want = pending_results.pop_front();
        if (out_value_out !== want.value || out_status !== want.status ||
            out_occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] result mismatch: expected value %0d status %0d occupancy %0d",
                     $time, want.value, want.status, want.occupancy);
            $display("[%0t]   got value %0d status %0d occupancy %0d",
                     $time, out_value_out, out_status, out_occupancy);
          end
        end
      end
    end
  end

  // Watchdog: a word moving on either side restarts the count.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_operation   <= OP_ENQUEUE;
    in_value_in    <= '0;
    in_priority_in <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_fill_and_overflow();
    test_removals();
    test_random_traffic(RANDOM_WORDS);
    drain_queue();

    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_mem.sv
rtl/spq_scan.sv
rtl/stable_priority_queue.sv
tb/sv/tb_stable_priority_queue.sv
